>>> rtl/rotozoom_texel_fetch_core_assert.svh
// assertion macros for the rotozoom texel fetch core
// used by the top level only, no other dependencies
`ifndef ROTOZOOM_TEXEL_FETCH_CORE_ASSERT_SVH
`define ROTOZOOM_TEXEL_FETCH_CORE_ASSERT_SVH

// same-cycle implication
`define RTF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rtf_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the q1.14 sine table for the rotozoom texel fetch
// no dependencies
package rtf_pkg;

	localparam int TEX_DEPTH_DEF     = 65536;
	localparam int SCREEN_WIDTH_DEF  = 320;
	localparam int SCREEN_HEIGHT_DEF = 200;

	localparam int X_W    = 9;
	localparam int Y_W    = 8;
	localparam int ADDR_W = 16;
	localparam int PIX_W  = 8;
	localparam int DIM_W  = 9;
	localparam int TRIG_W = 16;
	localparam int FRAC_W = 28;
	localparam int PROD_W = 45;
	localparam int MAG_W  = 11;
	localparam int RAW_W  = 17;
	localparam int Q_DEPTH = 4;

	localparam logic signed [PROD_W-1:0] POS_OFFSET = PROD_W'(64) <<< FRAC_W;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_DRAW  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		CFG_TEX_WIDTH  = 2'd0,
		CFG_TEX_HEIGHT = 2'd1,
		CFG_ANGLE_DEG  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		op_t               op;
		logic [X_W-1:0]    x;
		logic [Y_W-1:0]    y;
		logic [ADDR_W-1:0] texel_address;
		logic [PIX_W-1:0]  texel_value;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] color;
		logic [7:0]       tex_u;
		logic [7:0]       tex_v;
	} out_item_t;

	// effective configuration, already clamped
	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [8:0]       ang;
	} cfg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic logic signed [TRIG_W-1:0] quarter_q14(input logic [6:0] d);
		logic signed [TRIG_W-1:0] r;
		case (d)
			7'd0: r = 16'sd0;      7'd1: r = 16'sd286;    7'd2: r = 16'sd572;
			7'd3: r = 16'sd857;    7'd4: r = 16'sd1143;   7'd5: r = 16'sd1428;
			7'd6: r = 16'sd1713;   7'd7: r = 16'sd1997;   7'd8: r = 16'sd2280;
			7'd9: r = 16'sd2563;   7'd10: r = 16'sd2845;  7'd11: r = 16'sd3126;
			7'd12: r = 16'sd3406;  7'd13: r = 16'sd3686;  7'd14: r = 16'sd3964;
			7'd15: r = 16'sd4240;  7'd16: r = 16'sd4516;  7'd17: r = 16'sd4790;
			7'd18: r = 16'sd5063;  7'd19: r = 16'sd5334;  7'd20: r = 16'sd5604;
			7'd21: r = 16'sd5872;  7'd22: r = 16'sd6138;  7'd23: r = 16'sd6402;
			7'd24: r = 16'sd6664;  7'd25: r = 16'sd6924;  7'd26: r = 16'sd7182;
			7'd27: r = 16'sd7438;  7'd28: r = 16'sd7692;  7'd29: r = 16'sd7943;
			7'd30: r = 16'sd8192;  7'd31: r = 16'sd8438;  7'd32: r = 16'sd8682;
			7'd33: r = 16'sd8923;  7'd34: r = 16'sd9162;  7'd35: r = 16'sd9397;
			7'd36: r = 16'sd9630;  7'd37: r = 16'sd9860;  7'd38: r = 16'sd10087;
			7'd39: r = 16'sd10311; 7'd40: r = 16'sd10531; 7'd41: r = 16'sd10749;
			7'd42: r = 16'sd10963; 7'd43: r = 16'sd11174; 7'd44: r = 16'sd11381;
			7'd45: r = 16'sd11585; 7'd46: r = 16'sd11786; 7'd47: r = 16'sd11982;
			7'd48: r = 16'sd12176; 7'd49: r = 16'sd12365; 7'd50: r = 16'sd12551;
			7'd51: r = 16'sd12733; 7'd52: r = 16'sd12911; 7'd53: r = 16'sd13085;
			7'd54: r = 16'sd13255; 7'd55: r = 16'sd13421; 7'd56: r = 16'sd13583;
			7'd57: r = 16'sd13741; 7'd58: r = 16'sd13894; 7'd59: r = 16'sd14044;
			7'd60: r = 16'sd14189; 7'd61: r = 16'sd14330; 7'd62: r = 16'sd14466;
			7'd63: r = 16'sd14598; 7'd64: r = 16'sd14726; 7'd65: r = 16'sd14849;
			7'd66: r = 16'sd14968; 7'd67: r = 16'sd15082; 7'd68: r = 16'sd15191;
			7'd69: r = 16'sd15296; 7'd70: r = 16'sd15396; 7'd71: r = 16'sd15491;
			7'd72: r = 16'sd15582; 7'd73: r = 16'sd15668; 7'd74: r = 16'sd15749;
			7'd75: r = 16'sd15826; 7'd76: r = 16'sd15897; 7'd77: r = 16'sd15964;
			7'd78: r = 16'sd16026; 7'd79: r = 16'sd16083; 7'd80: r = 16'sd16135;
			7'd81: r = 16'sd16182; 7'd82: r = 16'sd16225; 7'd83: r = 16'sd16262;
			7'd84: r = 16'sd16294; 7'd85: r = 16'sd16322; 7'd86: r = 16'sd16344;
			7'd87: r = 16'sd16362; 7'd88: r = 16'sd16374; 7'd89: r = 16'sd16382;
			7'd90: r = 16'sd16384;
			default: r = 16'sd0;
		endcase
		return r;
	endfunction

	// a is 0..359
	function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [8:0] a);
		logic signed [TRIG_W-1:0] r;
		if (a < 9'd90)
			r = quarter_q14(7'(a));
		else if (a < 9'd180)
			r = quarter_q14(7'(9'd180 - a));
		else if (a < 9'd270)
			r = -quarter_q14(7'(a - 9'd180));
		else
			r = -quarter_q14(7'(9'd360 - a));
		return r;
	endfunction

endpackage

>>> rtl/rotozoom_texel_fetch_core.sv
`timescale 1ns / 1ps
// top level of the rotozoom texel fetch: config registers, front, queue, back
// depends on rtf_pkg, rtf_front, rtf_queue, rtf_back and the assert header
//
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    in_item_t  (op, x, y, texel_address, texel_value)
// out      out  out_valid / out_stall  out_item_t (color, tex_u, tex_v)
// cfg      in   cfg_we                 cfg_index, cfg_data
//
// one item per clock sustained while the output is not stalled; a draw result passes through
// the back pipeline (5 datapath stages, 11 wrap stages, 4 address stages, fetch)
// reset sets width and height to 256 and angle to 0; texture store is not cleared
// out_stall on a valid output freezes the whole back pipeline; a 4-entry queue keeps
// taking input until full; off-screen draws are dropped at the front, never queued
module rotozoom_texel_fetch_core import rtf_pkg::*; #(
	parameter int TEX_DEPTH     = TEX_DEPTH_DEF,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	`include "rotozoom_texel_fetch_core_assert.svh"

	logic [8:0] width_q, height_q, angle_q;
	cfg_t       cfg;
	q_stat_t    q_stat;
	logic       push, pop;
	in_item_t   push_item, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			angle_q  <= 9'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEX_WIDTH:  width_q  <= cfg_data;
				CFG_TEX_HEIGHT: height_q <= cfg_data;
				CFG_ANGLE_DEG:  angle_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, above 256 acts as 256
	assign cfg.w   = (width_q == '0) ? 9'd1 : (width_q > 9'd256) ? 9'd256 : width_q;
	assign cfg.h   = (height_q == '0) ? 9'd1 : (height_q > 9'd256) ? 9'd256 : height_q;
	assign cfg.ang = (angle_q >= 9'd360) ? angle_q - 9'd360 : angle_q;

	assign in_stall = q_stat.full;

	rtf_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
		.in_valid(in_valid), .in_data(in_data), .q_stat(q_stat),
		.push(push), .push_item(push_item)
	);

	rtf_queue #(.DEPTH(Q_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .head(head), .stat(q_stat)
	);

	rtf_back #(.TEX_DEPTH(TEX_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .q_stat(q_stat), .head(head),
		.pop(pop), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	`RTF_ASSERT_NOW(a_pop_nonempty, clk, arst_n, pop, !q_stat.empty, "pop from empty queue")
	`RTF_ASSERT_NEXT(a_push_lands, clk, arst_n, push, !q_stat.empty, "pushed item lost")
	`RTF_ASSERT_NOW(a_push_room, clk, arst_n, push, !in_stall, "push into full queue")

endmodule

>>> rtl/rtf_front.sv
`timescale 1ns / 1ps
// front: classifies incoming items, drops off-screen draws, pushes the rest
// depends on rtf_pkg
module rtf_front import rtf_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic     in_valid,
	input  in_item_t in_data,
	input  q_stat_t  q_stat,
	output logic     push,
	output in_item_t push_item
);

	logic on_screen;
	logic keep;

	assign on_screen = (32'(in_data.x) < 32'(SCREEN_WIDTH)) &&
		(32'(in_data.y) < 32'(SCREEN_HEIGHT));

	always_comb begin
		case (in_data.op)
			OP_DRAW:  keep = on_screen;
			OP_WRITE: keep = 1'b1;
			default:  keep = 1'b1;
		endcase
	end

	assign push      = in_valid && !q_stat.full && keep;
	assign push_item = in_data;

endmodule

>>> rtl/rtf_queue.sv
`timescale 1ns / 1ps
// small command queue between front and back
// depends on rtf_pkg
module rtf_queue import rtf_pkg::*; #(
	parameter int DEPTH = Q_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t push_item,
	input  logic     pop,
	output in_item_t head,
	output q_stat_t  stat
);

	localparam int PW = $clog2(DEPTH);

	in_item_t          buf_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= push_item;
	end

	assign head       = buf_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (32'(cnt_q) == DEPTH);

endmodule

>>> rtl/rtf_mod.sv
`timescale 1ns / 1ps
// pipelined restoring remainder, one dividend bit per stage, sign rides along
// depends on rtf_pkg
module rtf_mod import rtf_pkg::*; #(
	parameter int DVD_W = MAG_W,
	parameter int DIV_W = DIM_W
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DVD_W-1:0] mag,
	input  logic             neg,
	input  logic [DIV_W-1:0] divisor,
	output logic [DIV_W-1:0] rem,
	output logic             rem_neg
);

	logic [DIV_W-1:0] rem_q [DVD_W];
	logic [DVD_W-1:0] dv_q  [DVD_W];
	logic             neg_q [DVD_W];

	for (genvar i = 0; i < DVD_W; i++) begin : g_stage
		logic [DIV_W-1:0] prev_rem;
		logic [DVD_W-1:0] prev_dv;
		logic             prev_neg;
		logic [DIV_W:0]   t;
		logic [DIV_W:0]   d;

		if (i == 0) begin : g_first
			assign prev_rem = '0;
			assign prev_dv  = mag;
			assign prev_neg = neg;
		end else begin : g_rest
			assign prev_rem = rem_q[i-1];
			assign prev_dv  = dv_q[i-1];
			assign prev_neg = neg_q[i-1];
		end

		assign t = {prev_rem, prev_dv[DVD_W-1]};
		assign d = {1'b0, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= (t >= d) ? DIV_W'(t - d) : DIV_W'(t);
				dv_q[i]  <= prev_dv << 1;
				neg_q[i] <= prev_neg;
			end
		end
	end

	assign rem     = rem_q[DVD_W-1];
	assign rem_neg = neg_q[DVD_W-1];

endmodule

>>> rtl/rtf_back.sv
`timescale 1ns / 1ps
// back: rotate/zoom datapath, wrap units, address reduction and texture store
// depends on rtf_pkg, rtf_mod
module rtf_back import rtf_pkg::*; #(
	parameter int TEX_DEPTH = TEX_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  q_stat_t   q_stat,
	input  in_item_t  head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int AW     = $clog2(TEX_DEPTH);
	localparam int NS     = 5 + MAG_W + 4;
	localparam int RCP    = (1 << RAW_W) / TEX_DEPTH;
	localparam int RCP_W  = RAW_W - 8 + 2;
	localparam int QM_W   = RAW_W + RCP_W;
	localparam logic [31:0] DEP = TEX_DEPTH;
	localparam int MOD_O  = 5 + MAG_W;

	typedef struct packed {
		logic              vld;
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  val;
	} side_t;

	side_t side_q [NS];
	logic  adv;

	logic [X_W-1:0]              x_s1;
	logic [Y_W-1:0]              y_s1;
	logic signed [TRIG_W-1:0]    sn_s1, cs_s1;
	logic signed [TRIG_W:0]      k_s1, k_s2, k_s3;
	logic signed [25:0]          xc_s2, ys_s2, xs_s2, yc_s2;
	logic signed [26:0]          au_s3, av_s3;
	logic signed [PROD_W-1:0]    pu_s4, pv_s4;
	logic [MAG_W-1:0]            mu_s5, mv_s5;
	logic                        nu_s5, nv_s5;
	logic [DIM_W-1:0]            ru, rv;
	logic                        rnu, rnv;
	logic [8:0]                  uf, vf;
	logic [7:0]                  u_f1, v_f1, u_f2, v_f2, u_f3, v_f3, u_f4, v_f4;
	logic [RAW_W-1:0]            vw_f1, sel, sel_f2, r0_f3;
	logic [QM_W-1:0]             qm_f2;
	logic [AW-1:0]               idx_f4;
	logic [PIX_W-1:0]            tex_mem [TEX_DEPTH];
	logic [PIX_W-1:0]            rd_q;
	logic [7:0]                  u_q, v_q;
	logic                        vld_q;
	logic [8:0]                  cos_ang;
	logic signed [PROD_W-1:0]    abs_u, abs_v;
	logic [RAW_W-1:0]            r_fix;
	logic signed [25:0]          xc, ys, xs, yc;
	logic signed [43:0]          pku, pkv;
	logic [RAW_W-1:0]            vw;
	logic [QM_W-1:0]             qm;

	assign adv = !(vld_q && out_stall);
	assign pop = adv && !q_stat.empty;

	// side info shift line, one slot per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++)
				side_q[i] <= '0;
		end else if (adv) begin
			side_q[0].vld  <= pop;
			side_q[0].op   <= head.op;
			side_q[0].addr <= head.texel_address;
			side_q[0].val  <= head.texel_value;
			for (int i = 1; i < NS; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	assign cos_ang = (cfg.ang >= 9'd270) ? cfg.ang - 9'd270 : cfg.ang + 9'd90;

	assign xc  = $signed({1'b0, x_s1}) * cs_s1;
	assign ys  = $signed({1'b0, y_s1}) * sn_s1;
	assign xs  = $signed({1'b0, x_s1}) * sn_s1;
	assign yc  = $signed({1'b0, y_s1}) * cs_s1;
	assign pku = au_s3 * k_s3;
	assign pkv = av_s3 * k_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1  <= head.x;
			y_s1  <= head.y;
			sn_s1 <= sin_q14(cfg.ang);
			cs_s1 <= sin_q14(cos_ang);
			k_s1  <= (TRIG_W+1)'(sin_q14(cfg.ang)) + 17'sd16384;

			xc_s2 <= xc;
			ys_s2 <= ys;
			xs_s2 <= xs;
			yc_s2 <= yc;
			k_s2  <= k_s1;

			au_s3 <= 27'(xc_s2) - 27'(ys_s2);
			av_s3 <= 27'(xs_s2) + 27'(yc_s2);
			k_s3  <= k_s2;

			pu_s4 <= PROD_W'(pku) + POS_OFFSET;
			pv_s4 <= PROD_W'(pkv) + POS_OFFSET;

			// truncate toward zero: shift the magnitude
			nu_s5 <= pu_s4[PROD_W-1];
			nv_s5 <= pv_s4[PROD_W-1];
			mu_s5 <= abs_u[FRAC_W+MAG_W-1:FRAC_W];
			mv_s5 <= abs_v[FRAC_W+MAG_W-1:FRAC_W];
		end
	end

	assign abs_u = pu_s4[PROD_W-1] ? -pu_s4 : pu_s4;
	assign abs_v = pv_s4[PROD_W-1] ? -pv_s4 : pv_s4;

	rtf_mod #(.DVD_W(MAG_W), .DIV_W(DIM_W)) u_mod_u (
		.clk(clk), .en(adv), .mag(mu_s5), .neg(nu_s5), .divisor(cfg.w),
		.rem(ru), .rem_neg(rnu)
	);

	rtf_mod #(.DVD_W(MAG_W), .DIV_W(DIM_W)) u_mod_v (
		.clk(clk), .en(adv), .mag(mv_s5), .neg(nv_s5), .divisor(cfg.h),
		.rem(rv), .rem_neg(rnv)
	);

	// floor residue for negative coordinates
	assign uf = (rnu && ru != '0) ? cfg.w - ru : ru;
	assign vf = (rnv && rv != '0) ? cfg.h - rv : rv;
	assign vw = vf[7:0] * cfg.w;

	assign sel = (side_q[MOD_O].op == OP_DRAW) ? RAW_W'(u_f1) + vw_f1
		: RAW_W'(side_q[MOD_O].addr);
	assign qm = sel * RCP_W'(RCP);
	assign r_fix = (32'(r0_f3) >= DEP) ? RAW_W'(32'(r0_f3) - DEP) : r0_f3;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_f1  <= 8'(uf);
			v_f1  <= 8'(vf);
			vw_f1 <= vw;

			u_f2   <= u_f1;
			v_f2   <= v_f1;
			sel_f2 <= sel;
			qm_f2  <= qm;

			// quotient estimate is low by at most one
			u_f3  <= u_f2;
			v_f3  <= v_f2;
			r0_f3 <= sel_f2 - RAW_W'(qm_f2[QM_W-1:RAW_W] * DEP);

			u_f4   <= u_f3;
			v_f4   <= v_f3;
			idx_f4 <= AW'(r_fix);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && side_q[NS-1].vld && side_q[NS-1].op == OP_WRITE)
			tex_mem[idx_f4] <= side_q[NS-1].val;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q <= tex_mem[idx_f4];
			u_q  <= u_f4;
			v_q  <= v_f4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (adv)
			vld_q <= side_q[NS-1].vld && side_q[NS-1].op == OP_DRAW;
	end

	assign out_valid      = vld_q;
	assign out_data.color = rd_q;
	assign out_data.tex_u = u_q;
	assign out_data.tex_v = v_q;

endmodule
